FILE: hw/rtl/bfsll_pkg.sv
// Shared constants, command and state types for the level-size search block.
package bfsll_pkg;

    localparam int MAX_NODES  = 4096;
    localparam int MAX_DEGREE = 15;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int DEG_W      = 4;
    localparam int ADJ_DEPTH  = MAX_NODES * MAX_DEGREE;
    localparam int ADJ_AW     = $clog2(ADJ_DEPTH);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] MODE_DEG = 2'd0;
    localparam logic [1:0] MODE_ADJ = 2'd1;
    localparam logic [1:0] MODE_QRY = 2'd2;

    typedef enum logic [1:0] {
        CMD_DEG,
        CMD_ADJ,
        CMD_QRY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [NODE_W-1:0]   node;
        logic [ADJ_AW-1:0]   addr;
        logic [NODE_W-1:0]   data;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_QDEG,
        ST_VCLR,
        ST_POP,
        ST_VFETCH,
        ST_VDEG,
        ST_ADJ,
        ST_VIS,
        ST_FIN
    } back_state_t;

endpackage

FILE: hw/rtl/bfs_largest_level.sv
// Top level: configuration register, command front end and search back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in       | in_valid / in_ready    | mode, node, slot, neighbor, degree
//  out      | out_valid / out_ready  | boom_size, first_day
//  cfg      | cfg_we                 | cfg_data (nodes_in_use)
//
// Load transfers are written in the back end's idle state; mode 3 is dropped on entry.
// A query walks the graph through the degree, adjacency, visited and queue memories,
// each read through one registered read port.
// After reset every entry of the degree store is cleared with in_ready low.
// A four-entry command queue lets input transfers land while the back end searches;
// a finished result waits in the output register while the next query starts.
module bfs_largest_level (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [bfsll_pkg::NODE_W-1:0]      node,
    input  logic [3:0]                        slot,
    input  logic [bfsll_pkg::NODE_W-1:0]      neighbor,
    input  logic [bfsll_pkg::DEG_W-1:0]       degree,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bfsll_pkg::NODE_W-1:0]      boom_size,
    output logic [bfsll_pkg::NODE_W-1:0]      first_day,
    input  logic                              cfg_we,
    input  logic [bfsll_pkg::CNT_W-1:0]       cfg_data
);

    logic [bfsll_pkg::CNT_W-1:0] nodes_in_use_reg;
    logic                        clearing;
    logic                        cmd_valid;
    logic                        cmd_ready;
    bfsll_pkg::cmd_t             cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_in_use_reg <= bfsll_pkg::CNT_W'(bfsll_pkg::MAX_NODES);
        end
        else if (cfg_we)
        begin
            nodes_in_use_reg <= cfg_data;
        end
    end

    bfsll_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .node      (node),
        .slot      (slot),
        .neighbor  (neighbor),
        .degree    (degree),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    bfsll_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .nodes_in_use (nodes_in_use_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .boom_size    (boom_size),
        .first_day    (first_day)
    );

endmodule

FILE: hw/rtl/bfsll_front.sv
// Input side: accepts transfers, classifies them and queues commands for the back end.
module bfsll_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        mode,
    input  logic [bfsll_pkg::NODE_W-1:0]      node,
    input  logic [3:0]                        slot,
    input  logic [bfsll_pkg::NODE_W-1:0]      neighbor,
    input  logic [bfsll_pkg::DEG_W-1:0]       degree,
    input  logic                              clearing,
    output logic                              cmd_valid,
    input  logic                              cmd_ready,
    output bfsll_pkg::cmd_t                   cmd
);

    bfsll_pkg::cmd_t fifo_reg [bfsll_pkg::FIFO_DEPTH];
    logic [bfsll_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bfsll_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bfsll_pkg::FIFO_AW:0]   count_reg, count_next;
    bfsll_pkg::cmd_t new_cmd;
    logic keep;
    logic push;
    logic pop;
    logic [bfsll_pkg::DEG_W-1:0] deg_sat;

    assign in_ready  = (count_reg != (bfsll_pkg::FIFO_AW+1)'(bfsll_pkg::FIFO_DEPTH)) && !clearing;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        deg_sat = (32'(degree) > bfsll_pkg::MAX_DEGREE)
                  ? bfsll_pkg::DEG_W'(bfsll_pkg::MAX_DEGREE) : degree;
        new_cmd.node = node;
        // node * 15 + slot
        new_cmd.addr = {node, 4'b0000} - {4'b0000, node}
                       + {{(bfsll_pkg::ADJ_AW-4){1'b0}}, slot};
        new_cmd.data = neighbor;
        new_cmd.kind = bfsll_pkg::CMD_QRY;
        keep = 1'b0;
        unique case (mode)
            bfsll_pkg::MODE_DEG:
            begin
                new_cmd.kind = bfsll_pkg::CMD_DEG;
                new_cmd.data = {{(bfsll_pkg::NODE_W-bfsll_pkg::DEG_W){1'b0}}, deg_sat};
                keep = 1'b1;
            end
            bfsll_pkg::MODE_ADJ:
            begin
                new_cmd.kind = bfsll_pkg::CMD_ADJ;
                keep = (32'(slot) < bfsll_pkg::MAX_DEGREE);
            end
            bfsll_pkg::MODE_QRY:
            begin
                new_cmd.kind = bfsll_pkg::CMD_QRY;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && keep;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (bfsll_pkg::FIFO_AW+1)'(bfsll_pkg::FIFO_DEPTH))
        else $error("command queue overflow");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow push");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready && (count_reg == '0) |=> (rd_ptr_reg == $past(rd_ptr_reg)))
        else $error("pop from empty queue");
`endif

endmodule

FILE: hw/rtl/bfsll_back.sv
// Execution side: graph stores, breadth-first search sequencer and result register.
module bfsll_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bfsll_pkg::CNT_W-1:0]       nodes_in_use,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  bfsll_pkg::cmd_t                   cmd,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [bfsll_pkg::NODE_W-1:0]      boom_size,
    output logic [bfsll_pkg::NODE_W-1:0]      first_day
);

    localparam int NW = bfsll_pkg::NODE_W;
    localparam int CW = bfsll_pkg::CNT_W;
    localparam int DW = bfsll_pkg::DEG_W;
    localparam int AW = bfsll_pkg::ADJ_AW;

    // memories
    logic [DW-1:0]   deg_mem [bfsll_pkg::MAX_NODES];
    logic [NW-1:0]   adj_mem [bfsll_pkg::ADJ_DEPTH];
    logic            vis_mem [bfsll_pkg::MAX_NODES];
    logic [2*NW-1:0] q_mem   [bfsll_pkg::MAX_NODES];

    logic            deg_we;
    logic [NW-1:0]   deg_waddr, deg_raddr;
    logic [DW-1:0]   deg_wdata, deg_rd_reg;
    logic            adj_we;
    logic [AW-1:0]   adj_waddr, adj_raddr;
    logic [NW-1:0]   adj_wdata, adj_rd_reg;
    logic            vis_we;
    logic [NW-1:0]   vis_waddr, vis_raddr;
    logic            vis_wdata, vis_rd_reg;
    logic            q_we;
    logic [NW-1:0]   q_waddr, q_raddr;
    logic [2*NW-1:0] q_wdata, q_rd_reg;

    bfsll_pkg::back_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [NW-1:0] src_reg, src_next;
    logic [NW-1:0] lv_reg, lv_next;
    logic [AW-1:0] base_reg, base_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] deg_reg, deg_next;
    logic [NW-1:0] w_reg, w_next;
    logic [NW-1:0] cur_level_reg, cur_level_next;
    logic [NW-1:0] cur_count_reg, cur_count_next;
    logic [NW-1:0] best_count_reg, best_count_next;
    logic [NW-1:0] best_level_reg, best_level_next;
    logic          out_valid_reg, out_valid_next;
    logic [NW-1:0] boom_reg, boom_next;
    logic [NW-1:0] day_reg, day_next;

    logic [CW-1:0] limit;
    logic          out_free;
    logic [NW-1:0] qv;
    logic [NW-1:0] qlv;
    logic [DW:0]   a_inc;
    logic          fin_gt;
    logic [NW-1:0] fin_level;

    assign limit     = (nodes_in_use > CW'(bfsll_pkg::MAX_NODES))
                       ? CW'(bfsll_pkg::MAX_NODES) : nodes_in_use;
    assign out_free  = !out_valid_reg || out_ready;
    assign qv        = q_rd_reg[2*NW-1:NW];
    assign qlv       = q_rd_reg[NW-1:0];
    assign a_inc     = {1'b0, a_reg} + 1'b1;
    assign fin_gt    = cur_count_reg > best_count_reg;
    assign fin_level = fin_gt ? cur_level_reg : best_level_reg;

    assign clearing  = (state_reg == bfsll_pkg::ST_CLR);
    assign out_valid = out_valid_reg;
    assign boom_size = boom_reg;
    assign first_day = day_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        src_next        = src_reg;
        lv_next         = lv_reg;
        base_next       = base_reg;
        a_next          = a_reg;
        deg_next        = deg_reg;
        w_next          = w_reg;
        cur_level_next  = cur_level_reg;
        cur_count_next  = cur_count_reg;
        best_count_next = best_count_reg;
        best_level_next = best_level_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        boom_next       = boom_reg;
        day_next        = day_reg;
        cmd_ready       = 1'b0;
        deg_we          = 1'b0;
        deg_waddr       = idx_reg[NW-1:0];
        deg_wdata       = '0;
        deg_raddr       = src_reg;
        adj_we          = 1'b0;
        adj_waddr       = cmd.addr;
        adj_wdata       = cmd.data;
        adj_raddr       = base_reg + {{(AW-DW){1'b0}}, a_reg};
        vis_we          = 1'b0;
        vis_waddr       = idx_reg[NW-1:0];
        vis_wdata       = 1'b0;
        vis_raddr       = w_reg;
        q_we            = 1'b0;
        q_waddr         = tail_reg[NW-1:0];
        q_wdata         = {w_reg, lv_reg + 1'b1};
        q_raddr         = head_reg[NW-1:0];

        unique case (state_reg)
            bfsll_pkg::ST_CLR:
            begin
                deg_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CW'(bfsll_pkg::MAX_NODES - 1))
                begin
                    state_next = bfsll_pkg::ST_IDLE;
                end
            end
            bfsll_pkg::ST_IDLE:
            begin
                cmd_ready = cmd_valid;
                deg_raddr = cmd.node;
                if (cmd_valid)
                begin
                    unique case (cmd.kind)
                        bfsll_pkg::CMD_DEG:
                        begin
                            deg_we    = 1'b1;
                            deg_waddr = cmd.node;
                            deg_wdata = cmd.data[DW-1:0];
                        end
                        bfsll_pkg::CMD_ADJ:
                        begin
                            adj_we = 1'b1;
                        end
                        bfsll_pkg::CMD_QRY:
                        begin
                            src_next   = cmd.node;
                            state_next = bfsll_pkg::ST_QDEG;
                        end
                        default:
                        begin
                            state_next = bfsll_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bfsll_pkg::ST_QDEG:
            begin
                // source without edges answers without a search
                if (deg_rd_reg == '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        boom_next      = '0;
                        day_next       = '0;
                        state_next     = bfsll_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    idx_next   = '0;
                    state_next = bfsll_pkg::ST_VCLR;
                end
            end
            bfsll_pkg::ST_VCLR:
            begin
                vis_we = 1'b1;
                if (idx_reg < limit)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    vis_waddr       = src_reg;
                    vis_wdata       = 1'b1;
                    q_we            = 1'b1;
                    q_waddr         = '0;
                    q_wdata         = {src_reg, {NW{1'b0}}};
                    head_next       = '0;
                    tail_next       = CW'(1);
                    cur_level_next  = '0;
                    cur_count_next  = '0;
                    best_count_next = '0;
                    best_level_next = '0;
                    state_next      = bfsll_pkg::ST_POP;
                end
            end
            bfsll_pkg::ST_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    state_next = bfsll_pkg::ST_FIN;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = bfsll_pkg::ST_VFETCH;
                end
            end
            bfsll_pkg::ST_VFETCH:
            begin
                deg_raddr = qv;
                lv_next   = qlv;
                base_next = {qv, 4'b0000} - {4'b0000, qv};
                if (qlv != cur_level_reg)
                begin
                    if (cur_count_reg > best_count_reg)
                    begin
                        best_count_next = cur_count_reg;
                        best_level_next = cur_level_reg;
                    end
                    cur_count_next = NW'(1);
                    cur_level_next = qlv;
                end
                else
                begin
                    cur_count_next = cur_count_reg + 1'b1;
                end
                state_next = bfsll_pkg::ST_VDEG;
            end
            bfsll_pkg::ST_VDEG:
            begin
                deg_next  = deg_rd_reg;
                a_next    = '0;
                adj_raddr = base_reg;
                if (deg_rd_reg == '0)
                begin
                    state_next = bfsll_pkg::ST_POP;
                end
                else
                begin
                    state_next = bfsll_pkg::ST_ADJ;
                end
            end
            bfsll_pkg::ST_ADJ:
            begin
                vis_raddr = adj_rd_reg;
                w_next    = adj_rd_reg;
                if ({1'b0, adj_rd_reg} < limit)
                begin
                    state_next = bfsll_pkg::ST_VIS;
                end
                else
                begin
                    a_next    = a_inc[DW-1:0];
                    adj_raddr = base_reg + {{(AW-DW){1'b0}}, a_inc[DW-1:0]};
                    state_next = (a_inc == {1'b0, deg_reg})
                                 ? bfsll_pkg::ST_POP : bfsll_pkg::ST_ADJ;
                end
            end
            bfsll_pkg::ST_VIS:
            begin
                if (!vis_rd_reg && (tail_reg < CW'(bfsll_pkg::MAX_NODES)))
                begin
                    vis_we    = 1'b1;
                    vis_waddr = w_reg;
                    vis_wdata = 1'b1;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                a_next    = a_inc[DW-1:0];
                adj_raddr = base_reg + {{(AW-DW){1'b0}}, a_inc[DW-1:0]};
                state_next = (a_inc == {1'b0, deg_reg})
                             ? bfsll_pkg::ST_POP : bfsll_pkg::ST_ADJ;
            end
            bfsll_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    boom_next      = fin_gt ? cur_count_reg : best_count_reg;
                    // distance 0 winning is reported as distance 1
                    day_next       = (fin_level == '0) ? NW'(1) : fin_level;
                    state_next     = bfsll_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfsll_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfsll_pkg::ST_CLR;
            idx_reg        <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cur_level_reg  <= '0;
            cur_count_reg  <= '0;
            best_count_reg <= '0;
            best_level_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
            cur_level_reg  <= cur_level_next;
            cur_count_reg  <= cur_count_next;
            best_count_reg <= best_count_next;
            best_level_reg <= best_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        lv_reg   <= lv_next;
        base_reg <= base_next;
        a_reg    <= a_next;
        deg_reg  <= deg_next;
        w_reg    <= w_next;
        boom_reg <= boom_next;
        day_reg  <= day_next;
    end

    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        deg_rd_reg <= deg_mem[deg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vis_we)
        begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        vis_rd_reg <= vis_mem[vis_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_waddr] <= q_wdata;
        end
        q_rd_reg <= q_mem[q_raddr];
    end

`ifndef SYNTHESIS
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= CW'(bfsll_pkg::MAX_NODES))
        else $error("search queue tail out of range");
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfsll_pkg::ST_POP) |-> (head_reg <= tail_reg))
        else $error("search queue head passed tail");
    a_no_cmd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !cmd_ready)
        else $error("command taken during clearing pass");
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !out_valid_reg) |->
            (state_reg == bfsll_pkg::ST_FIN || state_reg == bfsll_pkg::ST_QDEG))
        else $error("result raised outside result states");
`endif

endmodule

FILE: sim/bfs_largest_level_tb.sv
// Testbench for bfs_largest_level: graph loads and searches checked against a local predictor.
module bfs_largest_level_tb;
    import bfsll_pkg::*;

    localparam logic [1:0] MODE_BAD = 2'd3;

    typedef struct {
        logic [NODE_W-1:0] size;
        logic [NODE_W-1:0] day;
    } level_result_t;

    class level_scoreboard;
        level_result_t pending[$];
        int errors;
        int checked;

        function void note(level_result_t r);
            pending.push_back(r);
        endfunction

        function void check(logic [NODE_W-1:0] size, logic [NODE_W-1:0] day);
            level_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result size=%0d day=%0d", $time, size, day);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (size !== e.size)
            begin
                $display("%0t: boom_size expected %0d actual %0d", $time, e.size, size);
                errors++;
            end
            if (day !== e.day)
            begin
                $display("%0t: first_day expected %0d actual %0d", $time, e.day, day);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] mode = '0;
    logic [NODE_W-1:0] node = '0;
    logic [3:0] slot = '0;
    logic [NODE_W-1:0] neighbor = '0;
    logic [DEG_W-1:0] degree = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [NODE_W-1:0] boom_size;
    logic [NODE_W-1:0] first_day;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;

    bfs_largest_level dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .node(node), .slot(slot), .neighbor(neighbor), .degree(degree),
        .out_valid(out_valid), .out_ready(out_ready),
        .boom_size(boom_size), .first_day(first_day),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // graph mirror
    logic [DEG_W-1:0]  deg_mem [MAX_NODES];
    logic [NODE_W-1:0] adj_mem [ADJ_DEPTH];
    bit                adj_set [ADJ_DEPTH];
    logic [CNT_W-1:0]  node_count;
    bit                seen [MAX_NODES];
    int                lvl [MAX_NODES];
    int                bfs_q [MAX_NODES];

    level_scoreboard sb;
    int  items_sent;
    int  queries_sent;
    bit  hold_req;
    bit  no_gaps;
    int  idle_cycles;

    function automatic level_result_t search_levels(int src);
        level_result_t r;
        int lim, head, tail, cur_lvl, cur_cnt, best_cnt, best_lvl, v, w;
        lim = (node_count < MAX_NODES) ? int'(node_count) : MAX_NODES;
        if (deg_mem[src] == 0)
        begin
            r.size = '0;
            r.day = '0;
            return r;
        end
        for (int i = 0; i < MAX_NODES; i++)
            seen[i] = 1'b0;
        head = 0; tail = 0; cur_lvl = 0; cur_cnt = 0; best_cnt = 0; best_lvl = 0;
        bfs_q[tail++] = src;
        seen[src] = 1'b1;
        lvl[src] = 0;
        while (head < tail)
        begin
            v = bfs_q[head++];
            if (lvl[v] != cur_lvl)
            begin
                if (cur_cnt > best_cnt)
                begin
                    best_cnt = cur_cnt;
                    best_lvl = cur_lvl;
                end
                cur_cnt = 0;
                cur_lvl = lvl[v];
            end
            cur_cnt++;
            for (int a = 0; a < deg_mem[v]; a++)
            begin
                w = adj_mem[v * MAX_DEGREE + a];
                if (w >= lim || seen[w] || tail >= MAX_NODES)
                    continue;
                seen[w] = 1'b1;
                lvl[w] = lvl[v] + 1;
                bfs_q[tail++] = w;
            end
        end
        if (cur_cnt > best_cnt)
        begin
            best_cnt = cur_cnt;
            best_lvl = cur_lvl;
        end
        if (best_lvl == 0)
            best_lvl = 1;
        r.size = best_cnt[NODE_W-1:0];
        r.day = best_lvl[NODE_W-1:0];
        return r;
    endfunction

    function automatic void apply_item(logic [1:0] m, int n, int s, int nb, int d);
        if (m == MODE_DEG)
            deg_mem[n] = (d > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : DEG_W'(d);
        else if (m == MODE_ADJ)
        begin
            if (s < MAX_DEGREE)
            begin
                adj_mem[n * MAX_DEGREE + s] = NODE_W'(nb);
                adj_set[n * MAX_DEGREE + s] = 1'b1;
            end
        end
        else if (m == MODE_QRY)
        begin
            sb.note(search_levels(n));
            queries_sent++;
        end
    endfunction

    // number of leading slots written, so a degree never exposes an unwritten slot
    function automatic int written_prefix(int n);
        int k;
        k = 0;
        while (k < MAX_DEGREE && adj_set[n * MAX_DEGREE + k])
            k++;
        return k;
    endfunction

    task automatic send_item(logic [1:0] m, int n, int s, int nb, int d);
        @(negedge clk);
        in_valid = 1'b1;
        mode = m;
        node = NODE_W'(n);
        slot = 4'(s);
        neighbor = NODE_W'(nb);
        degree = DEG_W'(d);
        do
            @(posedge clk);
        while (!in_ready);
        apply_item(m, n, s, nb, d);
        items_sent++;
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic burst_gap();
        if (!no_gaps && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 6));
    endtask

    task automatic write_node_count(int value);
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        // wait for loads still in the command queue to drain
        repeat (64) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = CNT_W'(value);
        @(negedge clk);
        cfg_we = 1'b0;
        node_count = CNT_W'(value);
    endtask

    task automatic random_item(int span);
        int pick, n, s, nb, p;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                       : $urandom_range(0, span - 1);
        if (pick < 40)
        begin
            s = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, 14);
            nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                            : $urandom_range(0, span - 1);
            send_item(MODE_ADJ, n, s, nb, $urandom_range(0, 15));
        end
        else if (pick < 65)
        begin
            p = written_prefix(n);
            send_item(MODE_DEG, n, $urandom_range(0, 15), $urandom_range(0, 4095),
                      $urandom_range(0, p));
        end
        else if (pick < 95)
            send_item(MODE_QRY, n, $urandom_range(0, 15), $urandom_range(0, 4095),
                      $urandom_range(0, 15));
        else
            send_item(MODE_BAD, n, $urandom_range(0, 15), $urandom_range(0, 4095),
                      $urandom_range(0, 15));
    endtask

    task automatic random_phase(int count, int span);
        repeat (count)
        begin
            random_item(span);
            burst_gap();
        end
    endtask

    // receiver stall pattern, with one long hold on request
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
            end
            hold = $urandom_range(0, 15);
            if (hold < 4)
                out_ready = 1'b0;
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check(boom_size, first_day);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 1000000)
        begin
            $display("%0t: watchdog expired", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        items_sent = 0;
        queries_sent = 0;
        hold_req = 1'b0;
        no_gaps = 1'b0;
        idle_cycles = 0;
        node_count = CNT_W'(4096);
        for (int i = 0; i < MAX_NODES; i++)
            deg_mem[i] = '0;
        for (int i = 0; i < ADJ_DEPTH; i++)
            adj_set[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty source, full fan-out, self loop, skipped ids, ignored items
        send_item(MODE_QRY, 0, 0, 0, 0);
        for (int s = 0; s < MAX_DEGREE; s++)
            send_item(MODE_ADJ, 1, s, s + 2, 0);
        send_item(MODE_ADJ, 1, 15, 4095, 0);
        send_item(MODE_DEG, 1, 0, 0, 15);
        send_item(MODE_QRY, 1, 0, 0, 0);
        send_item(MODE_ADJ, 4095, 0, 4095, 0);
        send_item(MODE_DEG, 4095, 0, 0, 1);
        send_item(MODE_QRY, 4095, 0, 0, 0);
        send_item(MODE_BAD, 4095, 15, 4095, 15);
        send_item(MODE_ADJ, 2, 0, 1, 0);
        send_item(MODE_DEG, 2, 0, 0, 1);
        send_item(MODE_QRY, 2, 0, 0, 0);
        idle_sender(2);

        write_node_count(1);
        send_item(MODE_QRY, 1, 0, 0, 0);
        send_item(MODE_QRY, 0, 0, 0, 0);
        random_phase(20, 32);

        write_node_count(4096);
        random_phase(20, 32);

        // long receiver hold while the sender keeps offering
        write_node_count(16);
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (12)
        begin
            random_item(16);
            send_item(MODE_QRY, $urandom_range(0, 15), 0, 0, 0);
        end
        no_gaps = 1'b0;

        write_node_count($urandom_range(2, 64));
        random_phase(20, 24);

        write_node_count(4096);
        random_phase(20, 32);
        idle_sender(1);

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d transfers including %0d searches; %0d results checked, %0d errors.",
                 items_sent, queries_sent, sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
